// ----- sv/srr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the selective-repeat receiver.
package srr_pkg;

    localparam int SEQ_COUNT_DEF   = 8;
    localparam int FRAME_BYTES_DEF = 16;

    localparam int SEQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int CKSUM_W = 16;
    localparam int WIN_W   = 2;
    localparam int KIND_W  = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam logic [WIN_W-1:0] WIN_RESET = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK  = 2'd0,
        KIND_NAK  = 2'd1,
        KIND_DATA = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic              done;
        result_kind_t      kind;
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage

// ----- sv/srr_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/selective_repeat_receiver.sv -----
`timescale 1ns / 1ps
// Selective-repeat ARQ receiver: checksum, window test, slot buffer and in-order delivery.
//
// Input channel s_*: one beat per frame byte; s_tlast marks a frame's last byte, which
// also carries the sender's checksum. Output channel m_*: ACK, NAK and delivered payload
// bytes; m_tlast marks the last result caused by one input beat. cfg_we/cfg_wdata write
// the window size (reset value 3); the user must do so only while the block is idle, as
// the block itself does not enforce it. Frame bytes are taken one per cycle while the
// block is idle and the output path is not backed up. A NAK or a re-ACK passes through the
// holding stage and output register to m_tvalid and does not stop the input. An in-window
// ACK stops the input while the buffered frames stream out: per slot a full check and a
// length read, then its payload bytes from the one read port of the slot buffer; a final
// full check and a close end the run, also for an ACK with nothing to deliver.
// The answer waits in a one-entry holding stage until it is known whether more results
// follow, so m_tlast is exact; the output register behind it lets a stalled m_tready
// back up into the holding stage and then into s_tready.
// Reset clears the slot-full flags, the window state and the running frame state;
// the slot buffer and length memory need no clearing pass.
module selective_repeat_receiver #(
    parameter int SEQ_COUNT   = srr_pkg::SEQ_COUNT_DEF,
    parameter int FRAME_BYTES = srr_pkg::FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [srr_pkg::WIN_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] frame_seq, [10:3] data_byte, [26:11] frame_checksum, rest zero
    input  logic [srr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] answer_seq, [10:3] out_byte, rest zero
    output logic [srr_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] result_kind, [2] frame_done
    output logic [srr_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    localparam int NE_W  = $clog2(SEQ_COUNT);
    localparam int CW    = NE_W + 1;
    localparam int BC_W  = $clog2(FRAME_BYTES + 1);
    localparam int SA_W  = $clog2(SEQ_COUNT * FRAME_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_LEN   = 5'b00100,
        ST_BYTES = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [srr_pkg::WIN_W-1:0]     win_reg;
    logic [SEQ_COUNT-1:0]          slot_full_reg, slot_full_next;
    logic [NE_W-1:0]               ne_reg, ne_next;
    logic [srr_pkg::CKSUM_W-1:0]   sum_reg, sum_next;
    logic [BC_W-1:0]               cnt_reg, cnt_next;
    logic                          term_reg, term_next;

    logic [BC_W-1:0]               idx_reg, idx_next;
    logic [BC_W-1:0]               len_reg, len_next;
    logic [SA_W-1:0]               base_reg, base_next;
    logic [srr_pkg::SEQ_W-1:0]     dseq_reg, dseq_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [srr_pkg::SEQ_W-1:0]     rd_seq_reg, rd_seq_next;
    logic                          rd_done_reg, rd_done_next;

    logic                          pend_valid_reg, pend_valid_next;
    logic                          pend_last_reg, pend_last_next;
    srr_pkg::result_t              pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_last_reg, out_last_next;
    srr_pkg::result_t              out_reg, out_next;

    // input fields
    logic [srr_pkg::SEQ_W-1:0]     in_seq;
    logic [srr_pkg::BYTE_W-1:0]    in_byte;
    logic [srr_pkg::CKSUM_W-1:0]   in_ck;

    logic                          s_fire;
    logic [CW-1:0]                 seq_ext, seq_wrap, dist_sum, dist_ext;
    logic [NE_W-1:0]               seq_mod;
    logic                          byte_taken;
    logic [srr_pkg::CKSUM_W-1:0]   sum_upd;
    logic [BC_W-1:0]               cnt_upd;
    logic                          good, in_win, in_prev;
    logic                          frame_end;

    logic                          store_we, store_re;
    logic [SA_W-1:0]               store_waddr, store_raddr;
    logic [srr_pkg::BYTE_W-1:0]    store_rdata;
    logic                          len_we, len_re;
    logic [BC_W-1:0]               len_rdata;

    logic                          out_free, move, take, load, issue;
    logic                          new_avail, new_last;
    srr_pkg::result_t              new_res;
    logic [NE_W-1:0]               ne_inc;

    assign in_seq  = s_tdata[2:0];
    assign in_byte = s_tdata[10:3];
    assign in_ck   = s_tdata[26:11];

    assign s_fire  = s_tvalid && s_tready;
    assign frame_end = s_fire && s_tlast;

    // sequence number modulo SEQ_COUNT; the field is below twice the count
    assign seq_ext  = CW'(in_seq);
    assign seq_wrap = (seq_ext >= CW'(SEQ_COUNT)) ? seq_ext - CW'(SEQ_COUNT) : seq_ext;
    assign seq_mod  = seq_wrap[NE_W-1:0];

    // modular distance from next_expected
    assign dist_sum = CW'(seq_mod) + CW'(SEQ_COUNT) - CW'(ne_reg);
    assign dist_ext = (dist_sum >= CW'(SEQ_COUNT)) ? dist_sum - CW'(SEQ_COUNT) : dist_sum;

    assign byte_taken = s_fire && !term_reg && (in_byte != '0)
                        && (cnt_reg < BC_W'(FRAME_BYTES));
    assign sum_upd = byte_taken ? sum_reg + srr_pkg::CKSUM_W'(in_byte) : sum_reg;
    assign cnt_upd = byte_taken ? cnt_reg + BC_W'(1) : cnt_reg;

    assign good    = (sum_upd == in_ck);
    assign in_win  = (dist_ext < CW'(win_reg));
    assign in_prev = (win_reg != '0) && (dist_ext >= CW'(SEQ_COUNT) - CW'(win_reg));

    assign store_we    = byte_taken && !slot_full_reg[seq_mod];
    assign store_waddr = SA_W'(seq_mod) * SA_W'(FRAME_BYTES) + SA_W'(cnt_reg);
    assign len_we      = frame_end && good && in_win && !slot_full_reg[seq_mod];

    assign ne_inc = (ne_reg == NE_W'(SEQ_COUNT - 1)) ? '0 : ne_reg + NE_W'(1);

    // holding stage and output register
    assign out_free = !out_valid_reg || m_tready;
    assign move     = pend_valid_reg && out_free && (pend_last_reg || new_avail);
    assign take     = new_avail && (!pend_valid_reg || move);
    assign load     = rd_valid_reg && take;

    assign s_tready = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);

    assign issue       = (state_reg == ST_BYTES) && (!rd_valid_reg || load);
    assign store_re    = issue;
    assign store_raddr = base_reg + SA_W'(idx_reg);
    assign len_re      = (state_reg == ST_CHECK) && slot_full_reg[ne_reg];

    always_comb begin
        new_avail    = 1'b0;
        new_last     = 1'b0;
        new_res.done = 1'b0;
        new_res.kind = srr_pkg::KIND_ACK;
        new_res.seq  = srr_pkg::SEQ_W'(seq_mod);
        new_res.data = '0;
        if (rd_valid_reg) begin
            new_avail    = 1'b1;
            new_res.kind = srr_pkg::KIND_DATA;
            new_res.seq  = rd_seq_reg;
            new_res.data = store_rdata;
            new_res.done = rd_done_reg;
        end else if (frame_end) begin
            if (!good) begin
                new_avail    = 1'b1;
                new_last     = 1'b1;
                new_res.kind = srr_pkg::KIND_NAK;
            end else if (in_win) begin
                new_avail = 1'b1;
            end else if (in_prev) begin
                new_avail = 1'b1;
                new_last  = 1'b1;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        slot_full_next = slot_full_reg;
        ne_next        = ne_reg;
        sum_next       = sum_upd;
        cnt_next       = cnt_upd;
        term_next      = term_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        base_next      = base_reg;
        dseq_next      = dseq_reg;
        rd_valid_next  = issue || (rd_valid_reg && !load);
        rd_seq_next    = rd_seq_reg;
        rd_done_next   = rd_done_reg;

        if (s_fire && !term_reg && (in_byte == '0)) begin
            term_next = 1'b1;
        end
        if (frame_end) begin
            sum_next  = '0;
            cnt_next  = '0;
            term_next = 1'b0;
            if (good && in_win) begin
                slot_full_next[seq_mod] = 1'b1;
                state_next = ST_CHECK;
            end
        end

        case (state_reg)
            ST_IDLE: begin
            end
            ST_CHECK: begin
                state_next = slot_full_reg[ne_reg] ? ST_LEN : ST_DONE;
            end
            ST_LEN: begin
                // slot leaves the window as soon as its length is known
                slot_full_next[ne_reg] = 1'b0;
                ne_next   = ne_inc;
                dseq_next = srr_pkg::SEQ_W'(ne_reg);
                base_next = SA_W'(ne_reg) * SA_W'(FRAME_BYTES);
                len_next  = len_rdata;
                idx_next  = '0;
                state_next = (len_rdata == '0) ? ST_CHECK : ST_BYTES;
            end
            ST_BYTES: begin
                if (issue) begin
                    rd_seq_next  = dseq_reg;
                    rd_done_next = (idx_reg == len_reg - BC_W'(1));
                    idx_next     = idx_reg + BC_W'(1);
                    if (idx_reg == len_reg - BC_W'(1)) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (!rd_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_next        = out_reg;

        if (move) begin
            out_valid_next = 1'b1;
            out_last_next  = pend_last_reg;
            out_next       = pend_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (take) begin
            pend_valid_next = 1'b1;
            pend_last_next  = new_last;
            pend_next       = new_res;
        end else if (move) begin
            pend_valid_next = 1'b0;
        end

        // run is closed once the last byte read has landed in the holding stage
        if (state_reg == ST_DONE && !rd_valid_reg) begin
            pend_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_reg        <= srr_pkg::WIN_RESET;
            slot_full_reg  <= '0;
            ne_reg         <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            term_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_we) begin
                win_reg <= cfg_wdata;
            end
            slot_full_reg  <= slot_full_next;
            ne_reg         <= ne_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            term_reg       <= term_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        base_reg     <= base_next;
        dseq_reg     <= dseq_next;
        rd_seq_reg   <= rd_seq_next;
        rd_done_reg  <= rd_done_next;
        pend_reg     <= pend_next;
        out_last_reg <= out_last_next;
        out_reg      <= out_next;
    end

    // payload bytes; writes only while idle, reads only while delivering
    srr_ram #(
        .WIDTH (srr_pkg::BYTE_W),
        .DEPTH (SEQ_COUNT * FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (in_byte),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    srr_ram #(
        .WIDTH (BC_W),
        .DEPTH (SEQ_COUNT)
    ) u_len (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (seq_mod),
        .wdata (cnt_upd),
        .re    (len_re),
        .raddr (ne_reg),
        .rdata (len_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(srr_pkg::M_TDATA_W - srr_pkg::SEQ_W - srr_pkg::BYTE_W){1'b0}},
                       out_reg.data, out_reg.seq};
    assign m_tuser  = {out_reg.done, out_reg.kind};

`ifndef NO_ASSERTIONS
    a_idle_pend_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && pend_valid_reg) |-> pend_last_reg)
        else $error("holding stage has an open run while idle");

    a_no_read_on_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rd_valid_reg)
        else $error("input taken while a buffer read is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> !slot_full_reg[seq_mod])
        else $error("write into a stored slot");

    a_len_of_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> slot_full_reg[ne_reg])
        else $error("delivery of an empty slot");

    a_run_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !rd_valid_reg) |=> (state_reg == ST_IDLE && pend_last_reg))
        else $error("delivery run not closed");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the selective-repeat receiver: directed table, random frames, scoreboard.
module testbench;

    localparam int SEQ_W     = srr_pkg::SEQ_W;
    localparam int BYTE_W    = srr_pkg::BYTE_W;
    localparam int CKSUM_W   = srr_pkg::CKSUM_W;
    localparam int WIN_W     = srr_pkg::WIN_W;
    localparam int S_TDATA_W = srr_pkg::S_TDATA_W;
    localparam int M_TDATA_W = srr_pkg::M_TDATA_W;
    localparam int M_TUSER_W = srr_pkg::M_TUSER_W;

    localparam int SEQ_N       = srr_pkg::SEQ_COUNT_DEF;
    localparam int SLOT_BYTES  = srr_pkg::FRAME_BYTES_DEF;
    // No correct run goes this long without a beat on either side.
    localparam int STALL_LIMIT = 2000;
    localparam int BLOCK_BEATS = 58;

    typedef struct packed {
        srr_pkg::result_kind_t kind;
        logic [SEQ_W-1:0]      seq;
        logic [BYTE_W-1:0]     data;
        logic                  done;
        logic                  last;
    } reply_t;

    typedef enum bit [2:0] {ROW_PREDICT, ROW_ACK, ROW_NAK, ROW_NONE, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t            op;
        bit [SEQ_W-1:0]     seq;
        bit [BYTE_W-1:0]    data;   // window size on a ROW_CFG row
        bit                 last;
        bit [CKSUM_W-1:0]   ck;
    } row_t;

    localparam int N_DIR = 21;
    row_t dir_rows [N_DIR] = '{
        '{ROW_NAK,     3'd2, 8'hFF, 1'b1, 16'h0000},   // bad checksum
        '{ROW_PREDICT, 3'd1, 8'h80, 1'b0, 16'h0000},
        '{ROW_ACK,     3'd1, 8'h7F, 1'b1, 16'h00FF},   // ahead of expected, held
        '{ROW_ACK,     3'd1, 8'h55, 1'b1, 16'h0055},   // duplicate of a held frame
        '{ROW_ACK,     3'd7, 8'h01, 1'b1, 16'h0001},   // previous window, acked again
        '{ROW_NONE,    3'd4, 8'h10, 1'b1, 16'h0010},   // outside both windows
        '{ROW_PREDICT, 3'd0, 8'h03, 1'b0, 16'h0000},
        '{ROW_PREDICT, 3'd0, 8'h00, 1'b0, 16'h0000},   // terminator
        '{ROW_PREDICT, 3'd0, 8'h44, 1'b1, 16'h0003},   // ignored byte; frees slots 0 and 1
        '{ROW_ACK,     3'd2, 8'h00, 1'b1, 16'h0000},   // empty payload
        '{ROW_PREDICT, 3'd3, 8'h11, 1'b0, 16'h0000},
        '{ROW_ACK,     3'd4, 8'h22, 1'b1, 16'h0033},   // seq changes inside the frame
        '{ROW_NAK,     3'd3, 8'hFF, 1'b1, 16'hFFFF},
        '{ROW_PREDICT, 3'd3, 8'h01, 1'b0, 16'h0000},
        '{ROW_PREDICT, 3'd3, 8'hFE, 1'b1, 16'h00FF},   // delivers slots 3 and 4
        '{ROW_CFG,     3'd0, 8'd0,  1'b0, 16'h0000},
        '{ROW_NONE,    3'd5, 8'h05, 1'b1, 16'h0005},   // window zero drops good frames
        '{ROW_NONE,    3'd4, 8'h01, 1'b1, 16'h0001},
        '{ROW_CFG,     3'd0, 8'd1,  1'b0, 16'h0000},
        '{ROW_NONE,    3'd6, 8'h06, 1'b1, 16'h0006},
        '{ROW_PREDICT, 3'd5, 8'h09, 1'b1, 16'h0009}
    };

    int win_plan [6] = '{3, 1, 2, 0, 3, 2};

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [WIN_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // receiver model state
    logic [BYTE_W-1:0]     buf_mem     [SEQ_N][SLOT_BYTES];
    logic [SLOT_BYTES-1:0] buf_written [SEQ_N];
    logic [4:0]            buf_len     [SEQ_N];
    logic                  buf_full    [SEQ_N];
    logic [SEQ_W-1:0]      next_exp;
    logic [CKSUM_W-1:0]    frame_sum;
    logic [4:0]            frame_cnt;
    logic                  frame_term;
    logic [WIN_W-1:0]      win_size;

    reply_t answer_q [$];

    int src_idle, rcv_idle;
    int errors, n_beats, n_ack, n_nak, n_data;
    int quiet;

    selective_repeat_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic model_reset();
        int k;
        for (k = 0; k < SEQ_N; k++) begin
            buf_full[k]    = 1'b0;
            buf_written[k] = '0;
            buf_len[k]     = '0;
        end
        next_exp   = '0;
        frame_sum  = '0;
        frame_cnt  = '0;
        frame_term = 1'b0;
        win_size   = srr_pkg::WIN_RESET;
    endtask

    // Sum and store one frame byte; a held frame is never overwritten.
    task automatic absorb_byte(input bit [SEQ_W-1:0] seq, input bit [BYTE_W-1:0] b);
        if (!frame_term) begin
            if (b == 8'd0) begin
                frame_term = 1'b1;
            end else if (frame_cnt < SLOT_BYTES) begin
                if (!buf_full[seq]) begin
                    buf_mem[seq][frame_cnt]     = b;
                    buf_written[seq][frame_cnt] = 1'b1;
                end
                frame_sum = frame_sum + CKSUM_W'(b);
                frame_cnt = frame_cnt + 5'd1;
            end
        end
    endtask

    // Answer a frame end and release whatever is now in order.
    task automatic close_frame(input bit [SEQ_W-1:0] seq, input bit [CKSUM_W-1:0] ck,
                               input bit push);
        reply_t           run [$];
        bit [SEQ_W-1:0]   gap, e;
        int               k, i;
        gap = seq - next_exp;
        if (frame_sum != ck) begin
            run.push_back('{srr_pkg::KIND_NAK, seq, 8'd0, 1'b0, 1'b0});
        end else if (gap < win_size) begin
            if (!buf_full[seq]) begin
                buf_full[seq] = 1'b1;
                buf_len[seq]  = frame_cnt;
            end
            run.push_back('{srr_pkg::KIND_ACK, seq, 8'd0, 1'b0, 1'b0});
            for (k = 0; k < SEQ_N && buf_full[next_exp]; k++) begin
                e = next_exp;
                for (i = 0; i < buf_len[e]; i++)
                    run.push_back('{srr_pkg::KIND_DATA, e, buf_mem[e][i],
                                    i == buf_len[e] - 1, 1'b0});
                buf_full[e] = 1'b0;
                next_exp    = e + SEQ_W'(1);
            end
        end else if (win_size != 0 && int'(gap) >= SEQ_N - int'(win_size)) begin
            run.push_back('{srr_pkg::KIND_ACK, seq, 8'd0, 1'b0, 1'b0});
        end
        frame_sum  = '0;
        frame_cnt  = '0;
        frame_term = 1'b0;
        if (run.size() != 0) run[run.size() - 1].last = 1'b1;
        if (push)
            for (i = 0; i < run.size(); i++) answer_q.push_back(run[i]);
    endtask

    // True when a good checksum here would store a slot with never-written bytes.
    function automatic bit store_unsafe(input bit [SEQ_W-1:0] seq);
        bit [SEQ_W-1:0] gap;
        int             i;
        gap = seq - next_exp;
        if (gap >= win_size || buf_full[seq]) return 1'b0;
        for (i = 0; i < frame_cnt; i++)
            if (!buf_written[seq][i]) return 1'b1;
        return 1'b0;
    endfunction

    task automatic send_beat(input bit [SEQ_W-1:0] seq, input bit [BYTE_W-1:0] b,
                             input bit last, input bit [CKSUM_W-1:0] ck);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, ck, b, seq};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_beats++;
    endtask

    // Hold the input off until every expected result is out, then settle.
    task automatic drain(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_window(input bit [WIN_W-1:0] v);
        drain(8);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        win_size   = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_frame();
        bit [BYTE_W-1:0]  bytes [$];
        bit [SEQ_W-1:0]   seq, bseq;
        bit [CKSUM_W-1:0] ck;
        int               r, len, i;
        r = $urandom_range(99);
        if (r < 60)      seq = next_exp + SEQ_W'($urandom_range(0, win_size));
        else if (r < 75) seq = next_exp - SEQ_W'($urandom_range(1, 3));
        else             seq = SEQ_W'($urandom);
        r = $urandom_range(99);
        if (r < 8)       len = 0;
        else if (r < 92) len = $urandom_range(1, 6);
        else             len = $urandom_range(7, SLOT_BYTES + 3);
        for (i = 0; i < len; i++) bytes.push_back(BYTE_W'($urandom_range(1, 255)));
        if (len == 0 || $urandom_range(99) < 12) begin
            bytes.push_back(8'd0);
            if (len != 0) repeat ($urandom_range(0, 2)) bytes.push_back(BYTE_W'($urandom));
        end
        for (i = 0; i < bytes.size(); i++) begin
            if (i != bytes.size() - 1) begin
                bseq = seq;
                if ($urandom_range(99) < 4) bseq = SEQ_W'($urandom);
                absorb_byte(bseq, bytes[i]);
                send_beat(bseq, bytes[i], 1'b0, CKSUM_W'($urandom));
            end else begin
                absorb_byte(seq, bytes[i]);
                r = $urandom_range(99);
                if (r < 4)       ck = CKSUM_W'($urandom);
                else if (r < 16) ck = frame_sum ^ CKSUM_W'($urandom_range(1, 16'hFFFF));
                else             ck = frame_sum;
                if (ck == frame_sum && store_unsafe(seq)) ck = ~ck;
                close_frame(seq, ck, 1'b1);
                send_beat(seq, bytes[i], 1'b1, ck);
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{srr_pkg::result_kind_t'(m_tuser[1:0]), m_tdata[2:0], m_tdata[10:3],
                    m_tuser[2], m_tlast};
            case (got.kind)
                srr_pkg::KIND_ACK:  n_ack++;
                srr_pkg::KIND_NAK:  n_nak++;
                default:            n_data++;
            endcase
            if (answer_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: kind %0d seq %0d byte %02h done %0b last %0b",
                             got.kind, got.seq, got.data, got.done, got.last);
            end else begin
                want = answer_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp kind %0d seq %0d byte %02h done %0b last %0b, %s",
                                 want.kind, want.seq, want.data, want.done, want.last,
                                 $sformatf("got kind %0d seq %0d byte %02h done %0b last %0b",
                                           got.kind, got.seq, got.data, got.done, got.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        row_t row;
        int   i, blk, start;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        quiet     = 0;
        errors    = 0;
        n_beats   = 0;
        n_ack     = 0;
        n_nak     = 0;
        n_data    = 0;
        src_idle  = 7;
        rcv_idle  = 71;
        model_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            row = dir_rows[i];
            if (row.op == ROW_CFG) begin
                write_window(row.data[WIN_W-1:0]);
            end else begin
                absorb_byte(row.seq, row.data);
                if (row.last) begin
                    close_frame(row.seq, row.ck, row.op == ROW_PREDICT);
                    if (row.op == ROW_ACK)
                        answer_q.push_back('{srr_pkg::KIND_ACK, row.seq, 8'd0, 1'b0, 1'b1});
                    else if (row.op == ROW_NAK)
                        answer_q.push_back('{srr_pkg::KIND_NAK, row.seq, 8'd0, 1'b0, 1'b1});
                end
                send_beat(row.seq, row.data, row.last, row.ck);
            end
        end

        for (blk = 0; blk < 6; blk++) begin
            if (blk == 2) begin
                src_idle = 71;
                rcv_idle = 7;
            end else if (blk == 4) begin
                src_idle = 0;
                rcv_idle = 0;
            end
            write_window(WIN_W'(win_plan[blk]));
            start = n_beats;
            while (n_beats - start < BLOCK_BEATS) begin
                send_frame();
                if ($urandom_range(99) < 4) drain(0);
            end
        end

        drain(20);
        $display("Sent %0d frame beats; checked %0d acks, %0d naks, %0d delivered bytes.",
                 n_beats, n_ack, n_nak, n_data);
        $display("Windows 0 to 3, wrap, duplicates, long and empty payloads, three stall mixes.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
